// File: src/cdrs_pkg.sv
// Shared types and constants for the circular deque rotate and search core.
package cdrs_pkg;

    // Default sizes of the deque.
    localparam int DEPTH_DEF      = 64;
    localparam int DATA_WIDTH_DEF = 32;

    // Fixed widths of the port fields.
    localparam int MODE_W  = 3;
    localparam int VALUE_W = 32;
    localparam int POS_W   = 6;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 7;

    // Operation codes carried by the mode field.
    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH = 3'd0,
        MODE_POP  = 3'd1,
        MODE_FIND = 3'd2,
        MODE_ROTL = 3'd3,
        MODE_ROTR = 3'd4
    } t_mode;

    // Status codes returned with every result word.
    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    // Per-cell update selection.
    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_LOAD = 2'd1,
        CELL_SHL  = 2'd2,
        CELL_SHR  = 2'd3
    } t_cell_op;

    // Control handed to every cell of the chain.
    typedef struct packed {
        t_cell_op op;
        logic     cmp_en;
    } t_cell_ctl;

endpackage

// File: src/cdrs_cell.sv
// One storage cell of the deque chain: holds one word and compares it with the search key.
module cdrs_cell #(
    parameter int DATA_WIDTH = cdrs_pkg::DATA_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  cdrs_pkg::t_cell_ctl   i_ctl,
    input  logic [DATA_WIDTH-1:0] i_left,
    input  logic [DATA_WIDTH-1:0] i_right,
    input  logic [DATA_WIDTH-1:0] i_load,
    input  logic [DATA_WIDTH-1:0] i_key,
    input  logic                  i_live,
    output logic [DATA_WIDTH-1:0] o_data,
    output logic                  o_hit
);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;
    logic                  r_hit;

    // Select the next word: keep it, take the broadcast word, or take a neighbor's word.
    always_comb begin
        case (i_ctl.op)
            cdrs_pkg::CELL_HOLD: n_data = r_data;
            cdrs_pkg::CELL_LOAD: n_data = i_load;
            cdrs_pkg::CELL_SHL:  n_data = i_right;
            cdrs_pkg::CELL_SHR:  n_data = i_left;
            default:             n_data = r_data;
        endcase
    end

    // The word and the match flag are payload and need no reset.
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        if (i_ctl.cmp_en) begin
            r_hit <= i_live && (r_data == i_key);
        end
    end

    assign o_data = r_data;
    assign o_hit  = r_hit;

endmodule

// File: src/circular_deque_rotate_search_core.sv
// Top level of the circular deque core: cell chain, operation sequencer and result register.
//
// The deque is a row of DEPTH cells; cell 0 always holds the front element and cell
// count-1 the back element, so pop and both rotations move every word one cell at
// once and find compares all cells at once. For each operation, in the cycle a word
// is accepted all cells compare against the key and the back element is captured,
// and in the update cycle, once the output register is free or being drained, the
// chain is updated, the first match is encoded and the result is loaded into the
// output register. No new word is taken until that update is done; a result held by
// a stalled output delays the update cycle of the following operation. No clearing
// pass is needed after reset: cells beyond the element count are never reported.
module circular_deque_rotate_search_core #(
    parameter int DEPTH      = cdrs_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = cdrs_pkg::DATA_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [cdrs_pkg::MODE_W-1:0]   i_mode,
    input  logic [cdrs_pkg::VALUE_W-1:0]  i_value,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [cdrs_pkg::VALUE_W-1:0]  o_data_out,
    output logic [cdrs_pkg::POS_W-1:0]    o_position,
    output logic [cdrs_pkg::STAT_W-1:0]   o_status,
    output logic [cdrs_pkg::COUNT_W-1:0]  o_count
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state                       r_state;
    logic [cdrs_pkg::MODE_W-1:0]  r_mode;
    logic [DATA_WIDTH-1:0]        r_word;
    logic [DATA_WIDTH-1:0]        r_tail;
    logic [CW-1:0]                r_count;
    logic                         r_out_valid;
    logic [cdrs_pkg::VALUE_W-1:0] r_data_out;
    logic [cdrs_pkg::POS_W-1:0]   r_position;
    logic [cdrs_pkg::STAT_W-1:0]  r_status;
    logic [cdrs_pkg::COUNT_W-1:0] r_count_out;

    logic                         accept;
    logic                         out_free;
    logic                         commit;
    logic                         is_full;
    logic                         is_empty;
    logic [DATA_WIDTH-1:0]        key_word;
    logic [DATA_WIDTH-1:0]        load_word;
    logic [DATA_WIDTH-1:0]        tail_sel;
    logic [DEPTH-1:0]             live;
    logic [DEPTH-1:0]             hits;
    logic [DEPTH-1:0]             hit_low;
    logic [IW-1:0]                enc_pos;
    logic [CW-1:0]                n_count;
    logic [cdrs_pkg::VALUE_W-1:0] n_data_out;
    logic [cdrs_pkg::POS_W-1:0]   n_position;
    logic [cdrs_pkg::STAT_W-1:0]  n_status;

    logic [DATA_WIDTH-1:0]        cell_data  [DEPTH];
    logic [DATA_WIDTH-1:0]        cell_left  [DEPTH];
    logic [DATA_WIDTH-1:0]        cell_right [DEPTH];
    cdrs_pkg::t_cell_ctl          cell_ctl   [DEPTH];

    // Handshake on both sides.
    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign commit     = (r_state == S_EXEC) && out_free;
    assign key_word   = DATA_WIDTH'(i_value);
    assign is_full    = (r_count == CW'(DEPTH));
    assign is_empty   = (r_count == '0);

    // Mark the cells that hold elements and pick out the back element.
    always_comb begin
        tail_sel = '0;
        for (int i = 0; i < DEPTH; i++) begin
            live[i] = (CW'(i) < r_count);
            if (CW'(i) == r_count - CW'(1)) begin
                tail_sel = tail_sel | cell_data[i];
            end
        end
    end

    // Word broadcast to a loading cell.
    always_comb begin
        case (r_mode)
            cdrs_pkg::MODE_ROTL: load_word = cell_data[0];
            cdrs_pkg::MODE_ROTR: load_word = r_tail;
            default:             load_word = r_word;
        endcase
    end

    // Per-cell control for the update cycle.
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            cell_ctl[i].cmp_en = accept;
            cell_ctl[i].op     = cdrs_pkg::CELL_HOLD;
            if (commit) begin
                case (r_mode)
                    cdrs_pkg::MODE_PUSH: begin
                        if (!is_full && CW'(i) == r_count) begin
                            cell_ctl[i].op = cdrs_pkg::CELL_LOAD;
                        end
                    end
                    cdrs_pkg::MODE_POP: begin
                        if (!is_empty) begin
                            cell_ctl[i].op = cdrs_pkg::CELL_SHL;
                        end
                    end
                    cdrs_pkg::MODE_ROTL: begin
                        if (!is_empty) begin
                            cell_ctl[i].op = (CW'(i) == r_count - CW'(1)) ?
                                             cdrs_pkg::CELL_LOAD : cdrs_pkg::CELL_SHL;
                        end
                    end
                    cdrs_pkg::MODE_ROTR: begin
                        if (!is_empty) begin
                            cell_ctl[i].op = (i == 0) ? cdrs_pkg::CELL_LOAD
                                                      : cdrs_pkg::CELL_SHR;
                        end
                    end
                    default: cell_ctl[i].op = cdrs_pkg::CELL_HOLD;
                endcase
            end
        end
    end

    // The chain of cells; the end cells feed themselves.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_first
            assign cell_left[g] = cell_data[g];
        end else begin : g_mid_l
            assign cell_left[g] = cell_data[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign cell_right[g] = cell_data[g];
        end else begin : g_mid_r
            assign cell_right[g] = cell_data[g+1];
        end

        cdrs_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (cell_ctl[g]),
            .i_left  (cell_left[g]),
            .i_right (cell_right[g]),
            .i_load  (load_word),
            .i_key   (key_word),
            .i_live  (live[g]),
            .o_data  (cell_data[g]),
            .o_hit   (hits[g])
        );
    end

    // Isolate the first match from the front and encode its position.
    always_comb begin
        hit_low = hits & ~(hits - DEPTH'(1));
        enc_pos = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (hit_low[i]) begin
                enc_pos = enc_pos | IW'(i);
            end
        end
    end

    // Result and element count of the operation being finished.
    always_comb begin
        n_count    = r_count;
        n_data_out = '0;
        n_position = '0;
        n_status   = cdrs_pkg::ST_OK;
        case (r_mode)
            cdrs_pkg::MODE_PUSH: begin
                if (is_full) begin
                    n_status = cdrs_pkg::ST_FULL;
                end else begin
                    n_count = r_count + CW'(1);
                end
            end
            cdrs_pkg::MODE_POP: begin
                if (is_empty) begin
                    n_status = cdrs_pkg::ST_EMPTY;
                end else begin
                    n_count    = r_count - CW'(1);
                    n_data_out = cdrs_pkg::VALUE_W'(cell_data[0]);
                end
            end
            cdrs_pkg::MODE_FIND: begin
                if (|hits) begin
                    n_position = cdrs_pkg::POS_W'(enc_pos);
                end else begin
                    n_status = cdrs_pkg::ST_NOTFOUND;
                end
            end
            cdrs_pkg::MODE_ROTL, cdrs_pkg::MODE_ROTR: begin
                if (is_empty) begin
                    n_status = cdrs_pkg::ST_EMPTY;
                end
            end
            default: n_status = cdrs_pkg::ST_OK;
        endcase
    end

    // Sequencer state, operation registers and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_mode  <= i_mode;
                        r_word  <= key_word;
                        r_tail  <= tail_sel;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (out_free) begin
                        r_count     <= n_count;
                        r_out_valid <= 1'b1;
                        r_data_out  <= n_data_out;
                        r_position  <= n_position;
                        r_status    <= n_status;
                        r_count_out <= cdrs_pkg::COUNT_W'(n_count);
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_data_out  = r_data_out;
    assign o_position  = r_position;
    assign o_status    = r_status;
    assign o_count     = r_count_out;

`ifndef SYNTHESIS
    // The element count never exceeds the depth.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("element count above depth");

    // An accepted word always leads to the update cycle.
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_EXEC))
        else $error("accepted word did not reach update cycle");

    // A push into a full deque leaves the count alone.
    a_full_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && r_mode == cdrs_pkg::MODE_PUSH && is_full) |=> (r_count == $past(r_count)))
        else $error("dropped push changed the count");

    // A match is only reported inside the held elements.
    a_find_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && r_mode == cdrs_pkg::MODE_FIND && (|hits)) |-> (CW'(enc_pos) < r_count))
        else $error("match reported beyond the back element");

    // Every finished operation presents a result on the next cycle.
    a_commit_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |=> o_out_valid)
        else $error("finished operation gave no result");
`endif

endmodule
